FILE: rtl/core/fmh_pkg.sv
// Shared types and constants for the FM/MFM mark hunter and byte decoder.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package fmh_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam int unsigned WinW    = 64;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned MarkW   = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HuntW   = 20;
  localparam int unsigned FreshW  = 5;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [FreshW-1:0] HuntFreshNeeded = 5'd16;
  localparam logic [HuntW-1:0]  HuntMax         = 20'hfffff;
  localparam logic [PhaseW-1:0] LastPhase       = 4'd15;
  localparam logic [15:0]       SearchLimitRst  = 16'd1200;
  localparam logic [3:0]        NbrMaskMfm      = 4'h5;
  localparam logic [3:0]        NbrMaskM2fm     = 4'hd;

  typedef enum logic [1:0] {
    OP_HUNT = 2'd0,
    OP_DATA = 2'd1,
    OP_LOAD = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_MARK      = 2'd0,
    KIND_EXHAUSTED = 2'd1,
    KIND_DATA      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ENC_FM   = 2'd0,
    ENC_MFM  = 2'd1,
    ENC_M2FM = 2'd2
  } enc_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENCODING = 2'd0,
    REG_BITREV   = 2'd1,
    REG_LIMIT    = 2'd2
  } reg_e;

  // table write request
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  idx;
    logic [WinW-1:0]  mask;
    logic [WinW-1:0]  match;
    logic [MarkW-1:0] mark;
  } tbl_wr_t;

  // table scan result
  typedef struct packed {
    logic             found;
    logic [MarkW-1:0] mark;
  } tbl_hit_t;

endpackage

`default_nettype wire

FILE: rtl/core/fmh_if.sv
// Valid/ready channel interfaces for input beats and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface fmh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        cell_bit;
  logic [3:0]  entry_index;
  logic [63:0] entry_mask;
  logic [63:0] entry_match;
  logic [3:0]  entry_mark;

  modport source (output valid, op, cell_bit, entry_index, entry_mask, entry_match,
                  entry_mark, input ready);
  modport sink (input valid, op, cell_bit, entry_index, entry_mask, entry_match,
                entry_mark, output ready);
endinterface

interface fmh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] mark_code;
  logic [7:0] data_byte;
  logic       suspect;

  modport source (output valid, kind, mark_code, data_byte, suspect, input ready);
  modport sink (input valid, kind, mark_code, data_byte, suspect, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fmh_mark_table.sv
// Address-mark table: per-slot mask/pattern/code registers and a
// first-match scan that stops at the first empty slot. Depends on fmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmh_mark_table #(
  parameter int unsigned ENTRIES = fmh_pkg::TableEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fmh_pkg::tbl_wr_t             wr_i,
  input  logic [fmh_pkg::WinW-1:0]     window_i,
  output fmh_pkg::tbl_hit_t            hit_o
);
  import fmh_pkg::*;

  logic [ENTRIES-1:0]  valid_q;
  logic [WinW-1:0]     mask_q  [ENTRIES];
  logic [WinW-1:0]     match_q [ENTRIES];
  logic [MarkW-1:0]    mark_q  [ENTRIES];
  logic [ENTRIES-1:0]  cmp;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
    logic sel;
    assign sel = wr_i.we && (int'(wr_i.idx) == g);

    // valid mirrors "mask is nonzero"; cleared at reset so the table is empty
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (sel) begin
        valid_q[g] <= |wr_i.mask;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sel) begin
        mask_q[g]  <= wr_i.mask;
        match_q[g] <= wr_i.match;
        mark_q[g]  <= wr_i.mark;
      end
    end

    assign cmp[g] = ((window_i ^ match_q[g]) & mask_q[g]) == '0;
  end

  always_comb begin
    logic stop;
    stop  = 1'b0;
    hit_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!stop) begin
        if (!valid_q[i]) begin
          stop = 1'b1;
        end else if (cmp[i]) begin
          hit_o.found = 1'b1;
          hit_o.mark  = mark_q[i];
          stop        = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fm_mfm_mark_hunt_and_byte_decode.sv
// FM/MFM address-mark hunter and data-byte decoder, top level.
// Path from input accept to result valid: input register, then result register.
// Throughput: one beat per cycle while results are taken; a waiting result lets one more beat
// into the input register, after which input stalls until the result is taken.
// Reset (async, active low): window, hunt and byte state cleared, table empty, FM mode,
// MSB-first assembly, search limit 1200 bytes. Depends on fmh_pkg, fmh_if, fmh_mark_table.
`timescale 1ns / 1ps
`default_nettype none

module fm_mfm_mark_hunt_and_byte_decode #(
  parameter int unsigned TABLE_ENTRIES = fmh_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fmh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fmh_pkg::CfgDataW-1:0]  cfg_wdata_i,
  fmh_in_if.sink                        in_ch_i,
  fmh_out_if.source                     out_ch_o
);
  import fmh_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers (to be written only while idle; the block does not enforce this)
  // ---------------------------------------------------------------------------
  logic [1:0]  enc_q;
  logic        bitrev_q;
  logic [15:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q    <= ENC_FM;
      bitrev_q <= 1'b0;
      limit_q  <= SearchLimitRst;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ENCODING: enc_q    <= cfg_wdata_i[1:0];
        REG_BITREV:   bitrev_q <= cfg_wdata_i[0];
        REG_LIMIT:    limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [1:0]        s1_op_q;
  logic              s1_bit_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [WinW-1:0]   s1_mask_q;
  logic [WinW-1:0]   s1_match_q;
  logic [MarkW-1:0]  s1_mark_q;

  logic out_valid_q;
  logic proc;     // stage 1 beat is decoded this cycle
  logic in_fire;

  // decode goes ahead when the result register is empty or being drained
  assign proc           = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready  = !s1_valid_q || proc;
  assign in_fire        = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= in_ch_i.op;
      s1_bit_q   <= in_ch_i.cell_bit;
      s1_idx_q   <= in_ch_i.entry_index;
      s1_mask_q  <= in_ch_i.entry_mask;
      s1_match_q <= in_ch_i.entry_match;
      s1_mark_q  <= in_ch_i.entry_mark;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode state
  // ---------------------------------------------------------------------------
  logic [WinW-1:0]   win_q,   win_d;
  logic [HuntW-1:0]  hunt_q,  hunt_d;
  logic [FreshW-1:0] fresh_q, fresh_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  accum_q, accum_d;
  logic              viol_q,  viol_d;

  logic [WinW-1:0]   win_shift;
  tbl_wr_t           tbl_wr;
  tbl_hit_t          tbl_hit;

  assign win_shift = {win_q[WinW-2:0], s1_bit_q};

  assign tbl_wr.we    = proc && (s1_op_q == OP_LOAD);
  assign tbl_wr.idx   = s1_idx_q;
  assign tbl_wr.mask  = s1_mask_q;
  assign tbl_wr.match = s1_match_q;
  assign tbl_wr.mark  = s1_mark_q;

  // table scans the window as it will be after this cell is shifted in
  fmh_mark_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .window_i (win_shift),
    .hit_o    (tbl_hit)
  );

  // Clock rule on the fresh window: bit 1 is the clock cell before this data cell.
  function automatic logic clock_broken(input logic [1:0] enc, input logic [3:0] w);
    logic clk;
    clk = w[1];
    case (enc_e'(enc))
      ENC_FM:   clock_broken = !clk;                       // missing clock
      ENC_MFM:  clock_broken = clk && |(w & NbrMaskMfm);   // clock next to a one
      ENC_M2FM: clock_broken = clk && |(w & NbrMaskM2fm);
      default:  clock_broken = 1'b0;                       // no rule
    endcase
  endfunction

  logic [HuntW-1:0]  hunt_inc;
  logic [FreshW-1:0] fresh_inc;
  logic              fresh_full;
  logic [HuntW-1:0]  budget;
  logic              res_load;
  logic [1:0]        res_kind;
  logic [MarkW-1:0]  res_mark;
  logic [ByteW-1:0]  res_byte;
  logic              res_suspect;

  assign hunt_inc   = (hunt_q == HuntMax) ? hunt_q : hunt_q + 1'b1;
  assign fresh_inc  = (fresh_q < HuntFreshNeeded) ? fresh_q + 1'b1 : fresh_q;
  assign fresh_full = fresh_inc >= HuntFreshNeeded;
  assign budget     = {limit_q, 4'b0000};   // bytes times sixteen cells

  always_comb begin
    win_d       = win_q;
    hunt_d      = hunt_q;
    fresh_d     = fresh_q;
    phase_d     = phase_q;
    accum_d     = accum_q;
    viol_d      = viol_q;
    res_load    = 1'b0;
    res_kind    = KIND_MARK;
    res_mark    = '0;
    res_byte    = '0;
    res_suspect = 1'b0;

    case (op_e'(s1_op_q))
      OP_HUNT: begin
        win_d   = win_shift;
        // a hunt cell drops any partial byte
        phase_d = '0;
        accum_d = '0;
        viol_d  = 1'b0;
        if (fresh_full && tbl_hit.found) begin
          // a match wins even on the cell that spends the budget
          res_load = 1'b1;
          res_kind = KIND_MARK;
          res_mark = tbl_hit.mark;
          hunt_d   = '0;
          fresh_d  = '0;
        end else if (hunt_inc >= budget) begin
          res_load = 1'b1;
          res_kind = KIND_EXHAUSTED;
          hunt_d   = '0;
          fresh_d  = '0;
        end else begin
          hunt_d  = hunt_inc;
          fresh_d = fresh_inc;
        end
      end
      OP_DATA: begin
        win_d   = win_shift;
        hunt_d  = '0;      // a data cell restarts the hunt
        fresh_d = '0;
        if (phase_q[0]) begin
          if (clock_broken(enc_q, win_shift[3:0])) begin
            viol_d = 1'b1;
          end
          accum_d = bitrev_q ? {s1_bit_q, accum_q[ByteW-1:1]}
                             : {accum_q[ByteW-2:0], s1_bit_q};
        end
        phase_d = phase_q + 1'b1;   // wraps to zero after the sixteenth cell
        if (phase_q == LastPhase) begin
          res_load    = 1'b1;
          res_kind    = KIND_DATA;
          res_byte    = accum_d;
          res_suspect = viol_d;
          accum_d     = '0;
          viol_d      = 1'b0;
        end
      end
      default: ;   // table loads and the unused op leave decode state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      hunt_q  <= '0;
      fresh_q <= '0;
      phase_q <= '0;
      accum_q <= '0;
      viol_q  <= 1'b0;
    end else if (proc) begin
      win_q   <= win_d;
      hunt_q  <= hunt_d;
      fresh_q <= fresh_d;
      phase_q <= phase_d;
      accum_q <= accum_d;
      viol_q  <= viol_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [1:0]       out_kind_q;
  logic [MarkW-1:0] out_mark_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_suspect_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_load) begin
      out_kind_q    <= res_kind;
      out_mark_q    <= res_mark;
      out_byte_q    <= res_byte;
      out_suspect_q <= res_suspect;
    end
  end

  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.kind      = out_kind_q;
  assign out_ch_o.mark_code = out_mark_q;
  assign out_ch_o.data_byte = out_byte_q;
  assign out_ch_o.suspect   = out_suspect_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fresh_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= HuntFreshNeeded)
    else $error("fresh cell count above saturation");

  a_mark_needs_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_load && res_kind == KIND_MARK) |-> fresh_full)
    else $error("mark reported before sixteen fresh cells");

  a_data_restarts_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_op_q == OP_DATA) |=> (hunt_q == '0 && fresh_q == '0))
    else $error("data cell did not restart the hunt");

  a_byte_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res_load && res_kind == KIND_DATA) |=>
      (phase_q == '0 && accum_q == '0 && !viol_q && out_valid_q))
    else $error("finished byte left stale byte state");

endmodule

`default_nettype wire

FILE: tb/fmh_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the FM/MFM mark hunter: mirrors the decode on every accepted input beat
// and compares result beats in order. Depends on fmh_pkg and fmh_if.

module fmh_decode_checker
  import fmh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  fmh_in_if                   in_mon_i,
  fmh_out_if                  out_mon_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  localparam int unsigned ReportMax    = 10;
  localparam int unsigned CellsPerByte = 16;

  typedef struct packed {
    kind_e            kind;
    logic [MarkW-1:0] mark_code;
    logic [ByteW-1:0] data_byte;
    logic             suspect;
  } decode_result_t;

  decode_result_t   expected_results[$];
  decode_result_t   oldest;

  logic [WinW-1:0]  window_q;
  logic [WinW-1:0]  slot_mask  [TableEntriesDef];
  logic [WinW-1:0]  slot_match [TableEntriesDef];
  logic [MarkW-1:0] slot_mark  [TableEntriesDef];
  int unsigned      hunt_used;
  int unsigned      fresh_used;
  int unsigned      byte_phase;
  logic [ByteW-1:0] byte_bits;
  logic             byte_bad;
  logic [1:0]       enc_mode;
  logic             lsb_first;
  logic [15:0]      limit_bytes;
  int               mismatches;

  // w[1] is the clock cell just ahead of the data cell in w[0]
  function automatic logic clock_rule_broken(input logic [WinW-1:0] w);
    case (enc_mode)
      ENC_FM:   return !w[1];
      ENC_MFM:  return w[1] && ((w[3:0] & NbrMaskMfm) != '0);
      ENC_M2FM: return w[1] && ((w[3:0] & NbrMaskM2fm) != '0);
      default:  return 1'b0;
    endcase
  endfunction

  task automatic decode_beat(input logic [1:0] op, input logic cbit,
                             input logic [IdxW-1:0] idx, input logic [WinW-1:0] mask,
                             input logic [WinW-1:0] match, input logic [MarkW-1:0] mark);
    decode_result_t res;
    logic           hit;
    logic           scanning;
    int             k;
    res = '0;
    hit = 1'b0;
    case (op)
      OP_LOAD: begin
        slot_mask[idx]  = mask;
        slot_match[idx] = match;
        slot_mark[idx]  = mark;
      end
      OP_HUNT: begin
        window_q   = {window_q[WinW-2:0], cbit};
        byte_phase = 0;
        byte_bits  = '0;
        byte_bad   = 1'b0;
        if (hunt_used < HuntMax) hunt_used++;
        if (fresh_used < HuntFreshNeeded) fresh_used++;
        if (fresh_used >= HuntFreshNeeded) begin
          scanning = 1'b1;
          for (k = 0; k < TableEntriesDef && scanning; k++) begin
            if (slot_mask[k] == '0) begin
              scanning = 1'b0;
            end else if (((window_q ^ slot_match[k]) & slot_mask[k]) == '0) begin
              res.kind      = KIND_MARK;
              res.mark_code = slot_mark[k];
              hit           = 1'b1;
              scanning      = 1'b0;
            end
          end
        end
        // a match wins over a spent budget
        if (hit || hunt_used >= CellsPerByte * limit_bytes) begin
          if (!hit) res.kind = KIND_EXHAUSTED;
          hunt_used  = 0;
          fresh_used = 0;
          expected_results.push_back(res);
        end
      end
      OP_DATA: begin
        window_q   = {window_q[WinW-2:0], cbit};
        hunt_used  = 0;
        fresh_used = 0;
        if (byte_phase[0]) begin
          if (clock_rule_broken(window_q)) byte_bad = 1'b1;
          byte_bits = lsb_first ? {cbit, byte_bits[ByteW-1:1]} : {byte_bits[ByteW-2:0], cbit};
        end
        if (byte_phase == LastPhase) begin
          res.kind      = KIND_DATA;
          res.data_byte = byte_bits;
          res.suspect   = byte_bad;
          expected_results.push_back(res);
          byte_phase = 0;
          byte_bits  = '0;
          byte_bad   = 1'b0;
        end else begin
          byte_phase++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   = '0;
      foreach (slot_mask[s]) begin
        slot_mask[s]  = '0;
        slot_match[s] = '0;
        slot_mark[s]  = '0;
      end
      hunt_used   = 0;
      fresh_used  = 0;
      byte_phase  = 0;
      byte_bits   = '0;
      byte_bad    = 1'b0;
      enc_mode    = ENC_FM;
      lsb_first   = 1'b0;
      limit_bytes = SearchLimitRst;
      mismatches  = 0;
      expected_results.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("%0t: result beat with none expected: kind %0d mark %0d byte %02h sus %0d",
                     $time, out_mon_i.kind, out_mon_i.mark_code, out_mon_i.data_byte,
                     out_mon_i.suspect);
        end else begin
          oldest = expected_results.pop_front();
          if (out_mon_i.kind !== oldest.kind || out_mon_i.mark_code !== oldest.mark_code ||
              out_mon_i.data_byte !== oldest.data_byte || out_mon_i.suspect !== oldest.suspect)
          begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("%0t: kind %0d/%0d mark %0d/%0d byte %02h/%02h sus %0d/%0d (exp/got)",
                       $time, oldest.kind, out_mon_i.kind, oldest.mark_code,
                       out_mon_i.mark_code, oldest.data_byte, out_mon_i.data_byte,
                       oldest.suspect, out_mon_i.suspect);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENCODING: enc_mode    = cfg_wdata_i[1:0];
          REG_BITREV:   lsb_first   = cfg_wdata_i[0];
          REG_LIMIT:    limit_bytes = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready)
        decode_beat(in_mon_i.op, in_mon_i.cell_bit, in_mon_i.entry_index, in_mon_i.entry_mask,
                    in_mon_i.entry_match, in_mon_i.entry_mark);
      fail_cnt_o <= mismatches;
      pending_o  <= expected_results.size();
    end
  end

endmodule

FILE: tb/tb_fm_mfm_mark_hunt_and_byte_decode.sv
`timescale 1ns / 1ps
// Testbench top for the FM/MFM mark hunter and byte decoder: directed beats, then random
// phases of mark hunts and encoded byte runs. Depends on fmh_pkg, fmh_if, fmh_decode_checker.

module tb_fm_mfm_mark_hunt_and_byte_decode;
  import fmh_pkg::*;

  localparam int unsigned ItemsTarget = 1750;
  localparam int unsigned GapShare    = 85;    // percent of the items during which gaps may be on
  localparam int unsigned DrainCycles = 4;     // accept reg + result reg, with margin
  localparam int unsigned IdleLimit   = 2000;  // cycles without any accepted beat or register write
  localparam logic [1:0]  OpUnused    = 2'd3;  // op code the block must ignore
  localparam logic [1:0]  EncNoRule   = 2'd3;  // encoding value with no clock rule

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  fmh_in_if  in_ch ();
  fmh_out_if out_ch ();

  int fail_cnt;
  int pending;

  // stimulus-side view of the table, only used to build matching cell runs
  logic [WinW-1:0] gen_mask  [TableEntriesDef];
  logic [WinW-1:0] gen_match [TableEntriesDef];
  int unsigned     table_len;
  logic [1:0]      enc_cur;
  logic [1:0]      cell_hist;     // [0] last cell sent, [1] the one before
  int unsigned     items_sent;
  logic            gaps_on;
  int unsigned     stall_left = 0;
  int unsigned     idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fm_mfm_mark_hunt_and_byte_decode dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch)
  );

  fmh_decode_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // Result side back-pressure: short random stalls while gaps are on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 6) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any beat on either channel or a register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WinW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly 16-cell marks, some wider, a few full-window or dense random masks.
  function automatic logic [WinW-1:0] pick_mask();
    logic [WinW-1:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: m = 64'h0000_0000_0000_ffff;
      5, 6:          m = 64'h0000_0000_ffff_ffff;
      7:             m = '1;
      default:       m = rand64();
    endcase
    return (m == '0) ? 64'h1 : m;
  endfunction

  // One input beat: optional sender gap, then hold valid until the beat is taken.
  task automatic send_beat(input logic [1:0] op, input logic cbit, input logic [IdxW-1:0] idx,
                           input logic [WinW-1:0] mask, input logic [WinW-1:0] match,
                           input logic [MarkW-1:0] mark);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.cell_bit    <= cbit;
    in_ch.entry_index <= idx;
    in_ch.entry_mask  <= mask;
    in_ch.entry_match <= match;
    in_ch.entry_mark  <= mark;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OpUnused) items_sent++;
    if (op == OP_HUNT || op == OP_DATA) cell_hist = {cell_hist[0], cbit};
  endtask

  // cell beat; table fields carry junk that the block must not look at
  task automatic cell_beat(input logic [1:0] op, input logic cbit);
    send_beat(op, cbit, 4'($urandom), rand64(), rand64(), 4'($urandom));
  endtask

  task automatic load_slot(input logic [IdxW-1:0] idx, input logic [WinW-1:0] mask,
                           input logic [WinW-1:0] match, input logic [MarkW-1:0] mark);
    send_beat(OP_LOAD, 1'($urandom), idx, mask, match, mark);
    gen_mask[idx]  = mask;
    gen_match[idx] = match;
  endtask

  // Fresh table: a few entries, sometimes all sixteen slots (no end marker then).
  task automatic load_table();
    int unsigned n;
    int unsigned s;
    n = ($urandom_range(0, 4) == 0) ? TableEntriesDef : $urandom_range(1, 5);
    for (s = 0; s < n; s++) load_slot(IdxW'(s), pick_mask(), rand64(), 4'($urandom));
    if (n < TableEntriesDef) load_slot(IdxW'(n), '0, rand64(), 4'($urandom));
    table_len = n;
  endtask

  // Hunt cells that leave the window matching one slot; noise bits where unmasked.
  task automatic mark_run(input int unsigned slot);
    int unsigned span;
    int          t;
    logic        b;
    repeat ($urandom_range(0, 6)) cell_beat(OP_HUNT, 1'($urandom));
    span = HuntFreshNeeded;
    for (t = 0; t < WinW; t++)
      if (gen_mask[slot][t] && t + 1 > span) span = t + 1;
    for (t = span - 1; t >= 0; t--) begin
      b = gen_mask[slot][t] ? gen_match[slot][t] : 1'($urandom);
      cell_beat(OP_HUNT, b);
    end
  endtask

  // Clock/data cell pairs encoded for the current mode, with rare planted violations.
  task automatic byte_run(input int unsigned n_bytes);
    logic [7:0] value;
    logic       d;
    logic       c;
    int         j;
    repeat (n_bytes) begin
      value = 8'($urandom);
      for (j = 7; j >= 0; j--) begin
        d = value[j];
        case (enc_cur)
          ENC_FM:   c = 1'b1;
          ENC_MFM:  c = !(cell_hist[0] | d);
          ENC_M2FM: c = !(cell_hist[0] | cell_hist[1] | d);
          default:  c = 1'($urandom);
        endcase
        if ($urandom_range(0, 24) == 0) c = !c;
        cell_beat(OP_DATA, c);
        cell_beat(OP_DATA, d);
      end
    end
  endtask

  // Broken sequences: stray cells of either kind, ignored ops, odd table writes.
  task automatic noise_run();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0:       send_beat(OpUnused, 1'($urandom), 4'($urandom), rand64(), rand64(),
                           4'($urandom));
        1:       load_slot(4'($urandom), pick_mask(), rand64(), 4'($urandom));
        2, 3, 4: cell_beat(OP_HUNT, 1'($urandom));
        default: cell_beat(OP_DATA, 1'($urandom));
      endcase
    end
  endtask

  // All three registers, back to back; upper data bits of the narrow ones are junk.
  task automatic write_regs(input logic [1:0] enc, input logic rev, input logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ENCODING;
    cfg_wdata <= {14'($urandom), enc};
    @(posedge clk);
    cfg_idx   <= REG_BITREV;
    cfg_wdata <= {15'($urandom), rev};
    @(posedge clk);
    cfg_idx   <= REG_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    enc_cur = enc;
  endtask

  // Idle point: every expected result back, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned pick;
    logic [1:0]  enc;
    logic        rev;
    logic [15:0] limit;
    int          j;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_ENCODING;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_HUNT;
    in_ch.cell_bit    = 1'b0;
    in_ch.entry_index = '0;
    in_ch.entry_mask  = '0;
    in_ch.entry_match = '0;
    in_ch.entry_mark  = '0;
    out_ch.ready      = 1'b0;
    gaps_on           = 1'b1;
    table_len         = 0;
    cell_hist         = '0;
    items_sent        = 0;
    enc_cur           = ENC_FM;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset settings (FM, MSB first, 1200 byte budget).
    // Slot 0: FM ID mark cells; slot 1: all-ones window; slot 2 ends the table;
    // slot 15 is written but sits past the end marker.
    load_slot(4'd0, 64'h0000_0000_0000_ffff, 64'h0000_0000_0000_f57e, 4'd1);
    load_slot(4'd1, '1, '1, 4'd15);
    load_slot(4'd2, '0, '0, 4'd0);
    load_slot(4'd15, 64'h8000_0000_0000_0001, '1, 4'd15);
    send_beat(OpUnused, 1'b1, '1, '1, '1, '1);
    // exactly sixteen hunt cells: the scan opens on the last one and slot 0 hits
    for (j = 15; j >= 0; j--) cell_beat(OP_HUNT, 1'(16'hf57e >> j));
    // partial byte, then a hunt cell throws it away
    repeat (2) begin
      cell_beat(OP_DATA, 1'b1);
      cell_beat(OP_DATA, 1'b0);
    end
    cell_beat(OP_HUNT, 1'b0);
    table_len = 2;
    drain();

    // Random phases; registers change only at idle points. A hunt left open at the
    // end of a phase may meet a lower budget in the next one.
    phase_no = 0;
    while (items_sent < ItemsTarget) begin
      gaps_on = (items_sent < ItemsTarget * GapShare / 100) && ($urandom_range(0, 3) != 0);
      case (phase_no)
        0: write_regs(ENC_MFM, 1'b0, 16'hffff);
        1: write_regs(ENC_M2FM, 1'b1, 16'd1);
        2: write_regs(EncNoRule, 1'b0, 16'd0);
        3: write_regs(ENC_FM, 1'b1, 16'd2);
        default: begin
          enc = ($urandom_range(0, 7) == 0) ? EncNoRule : 2'($urandom_range(0, 2));
          rev = 1'($urandom);
          case ($urandom_range(0, 11))
            0:       limit = 16'd0;
            1, 2:    limit = 16'd1;
            3:       limit = 16'hffff;
            4:       limit = SearchLimitRst;
            default: limit = 16'($urandom_range(2, 8));
          endcase
          write_regs(enc, rev, limit);
        end
      endcase
      if (phase_no == 0 || $urandom_range(0, 2) == 0) load_table();
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          // sector-like: mark, then a few bytes
          mark_run($urandom_range(0, table_len - 1));
          byte_run($urandom_range(1, 4));
        end else if (pick < 12) begin
          mark_run($urandom_range(0, table_len - 1));
        end else if (pick < 15) begin
          byte_run($urandom_range(1, 3));
        end else begin
          noise_run();
        end
      end
      drain();
      phase_no++;
    end

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/fmh_pkg.sv
rtl/core/fmh_if.sv
rtl/core/fmh_mark_table.sv
rtl/core/fm_mfm_mark_hunt_and_byte_decode.sv
tb/fmh_decode_checker.sv
tb/tb_fm_mfm_mark_hunt_and_byte_decode.sv
